>>> rtl/core/brsff_pkg.sv
package brsff_pkg;

    localparam int CMD_W     = 1;
    localparam int START_W   = 13;
    localparam int COUNT_W   = 13;
    localparam int INDEX_W   = 12;
    localparam int WORD_BITS = 64;
    localparam int BIT_SEL_W = 6;

    localparam logic [CMD_W-1:0] CMD_CHANGE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FIND   = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [START_W-1:0] start_bit;
        logic [COUNT_W-1:0] bit_count;
        logic               bit_value;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] found_index;
        logic               range_error;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_RUN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic run;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic issue_done;
        logic data_valid;
        logic data_last;
        logic hit;
    } t_dp_stat;

endpackage

>>> rtl/core/brsff_dp.sv
module brsff_dp
    import brsff_pkg::*;
#(
    parameter int BITMAP_BITS = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_item o_out_item
);

    localparam int WORDS = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IW    = ($clog2(BITMAP_BITS + 1) > COUNT_W + 1) ?
                           $clog2(BITMAP_BITS + 1) : COUNT_W + 1;
    localparam logic [IW-1:0]        CAP      = IW'(BITMAP_BITS);
    localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORDS-1:0]     r_wvalid;

    logic [CMD_W-1:0]     r_cmd;
    logic                 r_val;
    logic [START_W-1:0]   r_start;
    logic [COUNT_W-1:0]   r_cnt;
    logic [AW-1:0]        r_lo_w;
    logic [BIT_SEL_W-1:0] r_lo_b;
    logic [AW-1:0]        r_last_w;
    logic [BIT_SEL_W-1:0] r_last_b;
    logic                 r_err;
    logic [AW-1:0]        r_ptr;
    logic                 r_issue_done;
    logic                 r_dv;
    logic [AW-1:0]        r_dptr;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rvalid;
    logic                 r_found;
    logic [INDEX_W-1:0]   r_fidx;
    t_out_item            r_out_item;

    logic [IW-1:0]        s_ext;
    logic [IW-1:0]        c_ext;
    logic [IW-1:0]        sum_ext;
    logic [IW-1:0]        hi;
    logic [IW-1:0]        hi_m1;
    logic                 err;
    logic                 empty;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS-1:0] match;
    logic [BIT_SEL_W-1:0] pos;
    logic [IW-1:0]        fidx_full;
    logic                 do_write;
    logic                 do_capture;

    always_comb begin
        s_ext   = IW'(r_start);
        c_ext   = IW'(r_cnt);
        sum_ext = IW'({1'b0, r_start} + {1'b0, r_cnt});
        hi      = '0;
        err     = 1'b0;
        empty   = 1'b1;
        if (r_cmd == CMD_CHANGE) begin
            err   = sum_ext > CAP;
            hi    = err ? CAP : sum_ext;
            empty = s_ext >= hi;
        end else if (s_ext > c_ext) begin
            err   = 1'b1;
            empty = 1'b1;
        end else begin
            err   = c_ext > CAP;
            hi    = err ? CAP : c_ext;
            empty = s_ext >= hi;
        end
        hi_m1 = hi - IW'(1);
    end

    assign word    = r_rvalid ? r_rdata : '0;
    assign lo_mask = (r_dptr == r_lo_w) ? (ALL_ONES << r_lo_b) : ALL_ONES;
    assign hi_mask = (r_dptr == r_last_w) ?
                     (ALL_ONES >> (BIT_SEL_W'(WORD_BITS - 1) - r_last_b)) : ALL_ONES;
    assign mask    = lo_mask & hi_mask;
    assign wdata   = r_val ? (word | mask) : (word & ~mask);
    assign match   = (r_val ? word : ~word) & mask;

    always_comb begin
        pos = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (match[k]) begin
                pos = BIT_SEL_W'(k);
            end
        end
    end

    assign fidx_full  = (IW'(r_dptr) << BIT_SEL_W) | IW'(pos);
    assign do_write   = i_cmd.run && r_dv && (r_cmd == CMD_CHANGE);
    assign do_capture = i_cmd.run && r_dv && o_stat.hit && !r_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid     <= '0;
            r_dv         <= 1'b0;
            r_issue_done <= 1'b1;
            r_found      <= 1'b0;
        end else begin
            r_dv <= i_cmd.step;
            if (do_write) begin
                r_wvalid[r_dptr] <= 1'b1;
            end
            if (i_cmd.start) begin
                r_issue_done <= 1'b0;
                r_found      <= 1'b0;
            end else if (i_cmd.step) begin
                r_issue_done <= (r_ptr == r_last_w);
            end
            if (do_capture) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_in_item.command;
            r_val   <= i_in_item.bit_value;
            r_start <= i_in_item.start_bit;
            r_cnt   <= i_in_item.bit_count;
        end
        if (i_cmd.start) begin
            r_lo_w   <= AW'(s_ext >> BIT_SEL_W);
            r_lo_b   <= r_start[BIT_SEL_W-1:0];
            r_last_w <= AW'(hi_m1 >> BIT_SEL_W);
            r_last_b <= hi_m1[BIT_SEL_W-1:0];
            r_err    <= err;
            r_ptr    <= AW'(s_ext >> BIT_SEL_W);
            r_fidx   <= '0;
        end else begin
            if (i_cmd.step) begin
                r_ptr <= r_ptr + AW'(1);
            end
            if (do_capture) begin
                r_fidx <= fidx_full[INDEX_W-1:0];
            end
        end
        if (i_cmd.step) begin
            r_dptr   <= r_ptr;
            r_rdata  <= mem[r_ptr];
            r_rvalid <= r_wvalid[r_ptr];
        end
        if (do_write) begin
            mem[r_dptr] <= wdata;
        end
        if (i_cmd.emit) begin
            r_out_item.found       <= r_found;
            r_out_item.found_index <= r_fidx;
            r_out_item.range_error <= r_err;
        end
    end

    assign o_stat.empty      = empty;
    assign o_stat.issue_done = r_issue_done;
    assign o_stat.data_valid = r_dv;
    assign o_stat.data_last  = (r_dptr == r_last_w);
    assign o_stat.hit        = (r_cmd == CMD_FIND) && (|match);
    assign o_out_item        = r_out_item;

endmodule

>>> rtl/core/brsff_ctrl.sv
module brsff_ctrl
    import brsff_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;
    logic   finish;

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign finish     = i_stat.data_valid && (i_stat.data_last || i_stat.hit);
    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.start = 1'b1;
                n_state     = i_stat.empty ? S_RESULT : S_RUN;
            end
            S_RUN: begin
                o_cmd.run  = 1'b1;
                o_cmd.step = !i_stat.issue_done && !finish;
                if (finish) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> (r_state == S_RUN) && !i_stat.issue_done)
        else $error("word read issued past the last word");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !r_out_valid || !i_out_stall)
        else $error("result overwrote a waiting item");

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_PREP))
        else $error("accepted item did not enter preparation");

    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RUN) && finish) |=> (r_state == S_RESULT))
        else $error("walk finished without a result");

endmodule

>>> rtl/core/bitmap_range_set_find_first.sv
// Channel | Valid       | Stall       | Payload
// input   | i_in_valid  | o_in_stall  | i_in_item  (t_in_item)
// output  | o_out_valid | i_out_stall | o_out_item (t_out_item)
//
// An item walks the store one word per cycle over the words it touches, and a
// find stops at the word of its first hit.
// Reset is synchronous and active low, and it leaves the bitmap all zero.
// A finished item waits in the output register while the next item is taken.
// A stalled output does not hold the walk of the next item, only its result state.
module bitmap_range_set_find_first
    import brsff_pkg::*;
#(
    parameter int BITMAP_BITS = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    brsff_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    brsff_dp #(
        .BITMAP_BITS (BITMAP_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_out_item (o_out_item)
    );

endmodule
